/* rtl/core/lps_pkg.sv */
// Shared types and constants for the line pixel stepper.
// Holds the register map, command codes and the configuration bundle.
// No dependencies.
`default_nettype none

package lps_pkg;

  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_DISP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DISP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FG_COLOR    = 2'd2;

  localparam logic [15:0] DISP_WIDTH_RST  = 16'd1024;
  localparam logic [15:0] DISP_HEIGHT_RST = 16'd768;
  localparam logic [23:0] FG_COLOR_RST    = 24'hFFFFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic [15:0] disp_width;
    logic [15:0] disp_height;
    logic [23:0] fg_color;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lps_regs.sv */
// APB configuration registers: screen size and foreground color.
// Depends on lps_pkg.
`default_nettype none

module lps_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lps_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lps_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lps_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  output lps_pkg::cfg_t                      cfg_o
);
  import lps_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DISP_WIDTH:  cfg_d.disp_width  = pwdata[15:0];
        REG_DISP_HEIGHT: cfg_d.disp_height = pwdata[15:0];
        REG_FG_COLOR:    cfg_d.fg_color    = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DISP_WIDTH:  prdata = {16'd0, cfg_q.disp_width};
      REG_DISP_HEIGHT: prdata = {16'd0, cfg_q.disp_height};
      REG_FG_COLOR:    prdata = {8'd0, cfg_q.fg_color};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disp_width  <= DISP_WIDTH_RST;
      cfg_q.disp_height <= DISP_HEIGHT_RST;
      cfg_q.fg_color    <= FG_COLOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/lps_front.sv */
// Front end: takes command items, and for a load works out the major axis,
// endpoint order, minor direction and deltas. Packs an entry for the queue.
// Depends on lps_pkg.
`default_nettype none

module lps_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         command_i,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  output logic             [5*COORD_BITS+3:0] entry_o
);
  import lps_pkg::*;

  typedef struct packed {
    logic                         cmd;
    logic                         x_major;
    logic                         minor_inc;
    logic                         active;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [COORD_BITS-1:0] stop;
    logic        [COORD_BITS-1:0] d_major;
    logic        [COORD_BITS-1:0] d_minor;
  } entry_t;

  entry_t                     ent;
  logic signed [COORD_BITS:0] dx, dy, adx_w, ady_w;
  logic        [COORD_BITS-1:0] adx, ady;
  logic                       start_first;

  always_comb begin
    dx    = ((COORD_BITS+1)'(x_end_i) - (COORD_BITS+1)'(x_start_i));
    dy    = ((COORD_BITS+1)'(y_end_i) - (COORD_BITS+1)'(y_start_i));
    adx_w = dx[COORD_BITS] ? -dx : dx;
    ady_w = dy[COORD_BITS] ? -dy : dy;
    // |difference| never exceeds 2^COORD_BITS - 1
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];

    ent           = '0;
    ent.cmd       = command_i;
    ent.x_major   = (adx >= ady);
    ent.minor_inc = (dx > 0 && dy > 0) || (dx < 0 && dy < 0);
    start_first   = ent.x_major ? (dx > 0) : (dy > 0);
    ent.cur_x     = start_first ? x_start_i : x_end_i;
    ent.cur_y     = start_first ? y_start_i : y_end_i;
    if (ent.x_major) begin
      ent.stop    = start_first ? x_end_i : x_start_i;
      ent.d_major = adx;
      ent.d_minor = ady;
      ent.active  = (dx != 0);
    end else begin
      ent.stop    = start_first ? y_end_i : y_start_i;
      ent.d_major = ady;
      ent.d_minor = adx;
      ent.active  = (dy != 0);
    end
  end

  assign entry_o = ent;

endmodule

`default_nettype wire

/* rtl/core/lps_queue.sv */
// Short queue between front and back end, valid/ready on both sides.
// Depends on lps_pkg for the depth.
`default_nettype none

module lps_queue #(
  parameter int WIDTH = 84
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);
  import lps_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lps_back.sv */
// Back end: holds the line state, executes loads and steps, drives the
// registered result item. Depends on lps_pkg.
`default_nettype none

module lps_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire logic [5*COORD_BITS+3:0]       q_data_i,
  output logic                               q_ready_o,
  input  wire lps_pkg::cfg_t                 cfg_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]       pixel_x_o,
  output logic signed [COORD_BITS-1:0]       pixel_y_o,
  output logic        [23:0]                 pixel_color_o,
  output logic                               visible_o,
  output logic                               pixel_valid_o,
  output logic                               last_o
);
  import lps_pkg::*;

  localparam int EW = COORD_BITS + 4;   // error term
  localparam int CW = COORD_BITS + 16;  // clip compare

  typedef struct packed {
    logic                         cmd;
    logic                         x_major;
    logic                         minor_inc;
    logic                         active;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [COORD_BITS-1:0] stop;
    logic        [COORD_BITS-1:0] d_major;
    logic        [COORD_BITS-1:0] d_minor;
  } entry_t;

  entry_t ent;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, stop_q, stop_d;
  logic        [COORD_BITS-1:0] d_major_q, d_major_d, d_minor_q, d_minor_d;
  logic signed [EW-1:0]         err_q, err_d;
  logic                         x_major_q, x_major_d, minor_inc_q, minor_inc_d;
  logic                         active_q, active_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic        [23:0]           color_q, color_d;
  logic                         vis_q, vis_d, pv_q, pv_d, last_q, last_d;

  logic                         out_free, pop, is_step;
  logic signed [COORD_BITS-1:0] major, minor, new_major, new_minor;
  logic signed [EW-1:0]         dmin_e, dmaj_e, ld_dmin_e, ld_dmaj_e;
  logic                         fin;

  assign ent      = entry_t'(q_data_i);
  assign is_step  = (ent.cmd == CMD_STEP);
  assign out_free = !out_valid_q || out_ready_i;
  // a load makes no result, so it never waits; only a step waits for a free output
  assign q_ready_o = !is_step || out_free;
  assign pop       = q_valid_i && q_ready_o;

  always_comb begin
    dmin_e    = EW'($unsigned(d_minor_q));
    dmaj_e    = EW'($unsigned(d_major_q));
    ld_dmin_e = EW'($unsigned(ent.d_minor));
    ld_dmaj_e = EW'($unsigned(ent.d_major));

    major     = x_major_q ? cur_x_q : cur_y_q;
    minor     = x_major_q ? cur_y_q : cur_x_q;
    new_major = major + COORD_BITS'(1);
    if (err_q[EW-1]) begin
      new_minor = minor;
    end else if (minor_inc_q) begin
      new_minor = minor + COORD_BITS'(1);
    end else begin
      new_minor = minor - COORD_BITS'(1);
    end
    fin = (new_major >= stop_q);

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    stop_d      = stop_q;
    d_major_d   = d_major_q;
    d_minor_d   = d_minor_q;
    err_d       = err_q;
    x_major_d   = x_major_q;
    minor_inc_d = minor_inc_q;
    active_d    = active_q;

    out_valid_d = out_valid_q && !out_ready_i;
    px_d        = px_q;
    py_d        = py_q;
    color_d     = color_q;
    vis_d       = vis_q;
    pv_d        = pv_q;
    last_d      = last_q;

    if (pop && !is_step) begin
      cur_x_d     = ent.cur_x;
      cur_y_d     = ent.cur_y;
      stop_d      = ent.stop;
      d_major_d   = ent.d_major;
      d_minor_d   = ent.d_minor;
      x_major_d   = ent.x_major;
      minor_inc_d = ent.minor_inc;
      active_d    = ent.active;
      err_d       = (ld_dmin_e <<< 1) - ld_dmaj_e;
    end else if (pop) begin
      out_valid_d = 1'b1;
      if (!active_q) begin
        px_d    = '0;
        py_d    = '0;
        color_d = '0;
        vis_d   = 1'b0;
        pv_d    = 1'b0;
        last_d  = 1'b0;
      end else begin
        px_d    = cur_x_q;
        py_d    = cur_y_q;
        color_d = cfg_i.fg_color;
        vis_d   = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
                  (CW'($unsigned(cur_x_q)) < CW'(cfg_i.disp_width)) &&
                  (CW'($unsigned(cur_y_q)) < CW'(cfg_i.disp_height));
        pv_d    = 1'b1;
        last_d  = fin;
        cur_x_d = x_major_q ? new_major : new_minor;
        cur_y_d = x_major_q ? new_minor : new_major;
        err_d   = err_q[EW-1] ? err_q + (dmin_e <<< 1)
                              : err_q + ((dmin_e - dmaj_e) <<< 1);
        if (fin) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      stop_q      <= '0;
      d_major_q   <= '0;
      d_minor_q   <= '0;
      err_q       <= '0;
      x_major_q   <= 1'b0;
      minor_inc_q <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      stop_q      <= stop_d;
      d_major_q   <= d_major_d;
      d_minor_q   <= d_minor_d;
      err_q       <= err_d;
      x_major_q   <= x_major_d;
      minor_inc_q <= minor_inc_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    color_q <= color_d;
    vis_q   <= vis_d;
    pv_q    <= pv_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;
  assign visible_o     = vis_q;
  assign pixel_valid_o = pv_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* rtl/core/line_pixel_stepper.sv */
// Bresenham line rasterizer, one pixel per step item.
// Input channel (in_valid_i / in_ready_o): command_i = load (0) takes the
// endpoints; command_i = step (1) asks for the next pixel. A load gives no
// result item; every step gives exactly one, idle (pixel_valid_o = 0, all
// fields zero) when no line is active. The far endpoint is never emitted.
// Output channel (out_valid_o / out_ready_i): a registered result item.
// A step passes the queue and then the registered result item. Throughput: one
// item per cycle while the receiver takes results, set by the combinational add
// and compare of the back end on the line state.
// A two-entry queue parts the front end from the back end; while the
// receiver stalls, loads at the head of the queue still drain and up to two
// items queue before in_ready_o drops.
// Reset clears the line state (no line loaded) and sets the registers to width 1024,
// height 768, color 0xFFFFFF. Registers are written over APB at byte addresses 0, 4
// and 8; the user writes them only while the block is idle, which it does not enforce.
// Depends on lps_pkg, lps_regs, lps_front, lps_queue, lps_back.
`default_nettype none

module line_pixel_stepper #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lps_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lps_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lps_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic signed [COORD_BITS-1:0]   x_start_i,
  input  wire logic signed [COORD_BITS-1:0]   y_start_i,
  input  wire logic signed [COORD_BITS-1:0]   x_end_i,
  input  wire logic signed [COORD_BITS-1:0]   y_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [COORD_BITS-1:0]        pixel_x_o,
  output logic signed [COORD_BITS-1:0]        pixel_y_o,
  output logic        [23:0]                  pixel_color_o,
  output logic                                visible_o,
  output logic                                pixel_valid_o,
  output logic                                last_o
);
  import lps_pkg::*;

  localparam int EntryW = 5 * COORD_BITS + 4;

  cfg_t              cfg;
  logic [EntryW-1:0] entry, q_data;
  logic              q_valid, q_ready;

  lps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lps_front #(.COORD_BITS(COORD_BITS)) u_front (
    .command_i (command_i),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .entry_o   (entry)
  );

  lps_queue #(.WIDTH(EntryW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  lps_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_ready_o     (q_ready),
    .cfg_i         (cfg),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .visible_o     (visible_o),
    .pixel_valid_o (pixel_valid_o),
    .last_o        (last_o)
  );

`ifndef ASSERT_OFF
  // a step taken by the back end always shows a result on the next cycle
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && (q_data[EntryW-1] == CMD_STEP) |=> out_valid_o)
    else $error("step item produced no result");

  // idle result carries all-zero fields
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |->
      pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0 &&
      !visible_o && !last_o)
    else $error("idle result with nonzero fields");

  // visible and last only on an emitted pixel
  a_flags_need_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (visible_o || last_o) |-> pixel_valid_o)
    else $error("visible or last set without a pixel");
`endif

endmodule

`default_nettype wire
